### sv/rfw_pkg.sv
// shared types and constants for the rectangle fill write generator
package rfw_pkg;

  localparam int unsigned DEF_MAX_DIM   = 4096;
  localparam int unsigned DEF_ADDR_BITS = 32;

  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_FB_BASE    = 2'd0;
  localparam logic [1:0] REG_ROW_STRIDE = 2'd1;
  localparam logic [1:0] REG_PIXEL_MODE = 2'd2;

  typedef enum logic [1:0] {
    MODE_8BPP  = 2'd0,
    MODE_16BPP = 2'd1,
    MODE_32BPP = 2'd2,
    MODE_1BPP  = 2'd3
  } rfw_mode_e;

  typedef enum logic [1:0] {
    SEG_LEFT  = 2'd0,
    SEG_FULL  = 2'd1,
    SEG_RIGHT = 2'd2,
    SEG_ONE   = 2'd3
  } rfw_seg_e;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } rfw_req_e;

  typedef struct packed {
    logic [31:0] fb_base;
    logic [15:0] row_stride;
    rfw_mode_e   pixel_mode;
  } rfw_cfg_t;

  typedef struct packed {
    logic [31:0] write_addr;
    logic [31:0] write_data;
    logic [31:0] write_bits;
    logic        last_write;
  } rfw_wr_t;

endpackage

### sv/rfw_regs.sv
// apb configuration registers: framebuffer base, row stride, pixel mode
module rfw_regs import rfw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output rfw_cfg_t           cfg_o
);

  logic [31:0] fb_base_q;
  logic [15:0] row_stride_q;
  rfw_mode_e   pixel_mode_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_base_q    <= '0;
      row_stride_q <= '0;
      pixel_mode_q <= MODE_8BPP;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FB_BASE:    fb_base_q    <= pwdata;
        REG_ROW_STRIDE: row_stride_q <= pwdata[15:0];
        REG_PIXEL_MODE: pixel_mode_q <= rfw_mode_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FB_BASE:    prdata = fb_base_q;
      REG_ROW_STRIDE: prdata = {16'b0, row_stride_q};
      REG_PIXEL_MODE: prdata = {30'b0, pixel_mode_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = {fb_base_q, row_stride_q, pixel_mode_q};

endmodule

### sv/rfw_engine.sv
// rectangle walk state and per-beat write address, data and mask logic
module rfw_engine import rfw_pkg::*; #(
  parameter int unsigned MAX_DIM   = DEF_MAX_DIM,
  parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rfw_cfg_t    cfg_i,
  input  logic        step_i,
  input  logic        req_type_i,
  input  logic [11:0] rect_x_i,
  input  logic [11:0] rect_y_i,
  input  logic [12:0] rect_w_i,
  input  logic [12:0] rect_h_i,
  input  logic [31:0] fill_value_i,
  output logic        emit_o,
  output rfw_wr_t     wr_o
);

  localparam int unsigned AW    = ADDR_BITS;
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned SUM_W = ((DIM_W > 12) ? DIM_W : 12) + 1;
  localparam int unsigned EFX_W = SUM_W - 3;

  logic [AW-1:0]    row_base_q, row_base_d;
  logic [AW-1:0]    write_ptr_q, write_ptr_d;
  logic [DIM_W-1:0] cols_left_q, cols_left_d;
  logic [DIM_W-1:0] rows_left_q, rows_left_d;
  logic             busy_q, busy_d;
  rfw_seg_e         seg_q, seg_d;
  logic [31:0]      fill_q, fill_d;
  logic [11:0]      saved_x_q, saved_x_d;
  logic [DIM_W-1:0] saved_w_q, saved_w_d;

  logic [DIM_W-1:0] w_sat, h_sat;
  logic [27:0]      stride_prod;
  logic [AW-1:0]    rb_start, rb_next;
  logic             is_start;

  // row setup inputs and results
  logic [11:0]      br_x;
  logic [DIM_W-1:0] br_w;
  logic [AW-1:0]    br_rb;
  logic [SUM_W-1:0] br_sum;
  logic [9:0]       sfx;
  logic [EFX_W-1:0] efx;
  logic [13:0]      x_off;
  rfw_seg_e         br_seg;
  logic             br_load;
  logic [DIM_W-1:0] br_cols;
  logic [AW-1:0]    br_ptr;

  logic [2:0]  lb;
  logic [7:0]  lmask, rmask, color8, bits8;
  logic [31:0] pix_bits;
  logic [AW-1:0] out_addr, ptr_step;
  logic [AW+31:0] addr_pad;
  logic        row_done;
  logic [31:0] wr_data;
  logic [31:0] wr_bits;
  logic        wr_last;

  assign is_start = (req_type_i == REQ_START);

  assign w_sat = ({19'b0, rect_w_i} > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rect_w_i);
  assign h_sat = ({19'b0, rect_h_i} > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rect_h_i);

  assign stride_prod = cfg_i.row_stride * rect_y_i;
  assign rb_start    = AW'(cfg_i.fb_base) + AW'(stride_prod);
  assign rb_next     = row_base_q + AW'(cfg_i.row_stride);

  assign br_x  = is_start ? rect_x_i : saved_x_q;
  assign br_w  = is_start ? w_sat : saved_w_q;
  assign br_rb = is_start ? rb_start : rb_next;

  assign br_sum = SUM_W'(br_x) + SUM_W'(br_w);
  assign sfx    = 10'(({1'b0, br_x} + 13'd7) >> 3);
  assign efx    = br_sum[SUM_W-1:3];
  assign lb     = br_sum[2:0];

  always_comb begin
    case (cfg_i.pixel_mode)
      MODE_16BPP: x_off = {1'b0, br_x, 1'b0};
      MODE_32BPP: x_off = {br_x, 2'b00};
      default:    x_off = {2'b00, br_x};
    endcase
  end

  always_comb begin
    br_seg  = SEG_FULL;
    br_load = 1'b0;
    br_cols = br_w;
    br_ptr  = br_rb + AW'(x_off);
    if (cfg_i.pixel_mode == MODE_1BPP) begin
      br_ptr  = br_rb + AW'(sfx);
      br_cols = DIM_W'(efx - EFX_W'(sfx));
      if (EFX_W'(sfx) > efx) begin
        br_seg = SEG_ONE;
      end else if (br_x[2:0] != 3'd0) begin
        br_seg = SEG_LEFT;
      end else if (efx > EFX_W'(sfx)) begin
        br_seg  = SEG_FULL;
        br_load = 1'b1;
      end else begin
        br_seg = SEG_RIGHT;
      end
    end else begin
      br_load = 1'b1;
    end
  end

  assign lmask  = 8'hff >> saved_x_q[2:0];
  assign rmask  = ~(8'hff >> lb);
  assign color8 = {8{fill_q[0]}};

  always_comb begin
    case (cfg_i.pixel_mode)
      MODE_16BPP: begin
        pix_bits = 32'h0000_ffff;
        ptr_step = AW'(2);
      end
      MODE_32BPP: begin
        pix_bits = 32'hffff_ffff;
        ptr_step = AW'(4);
      end
      default: begin
        pix_bits = 32'h0000_00ff;
        ptr_step = AW'(1);
      end
    endcase
  end

  always_comb begin
    row_base_d  = row_base_q;
    write_ptr_d = write_ptr_q;
    cols_left_d = cols_left_q;
    rows_left_d = rows_left_q;
    busy_d      = busy_q;
    seg_d       = seg_q;
    fill_d      = fill_q;
    saved_x_d   = saved_x_q;
    saved_w_d   = saved_w_q;
    emit_o      = 1'b0;
    row_done    = 1'b0;
    out_addr    = write_ptr_q;
    bits8       = 8'h00;
    wr_data     = '0;
    wr_bits     = '0;
    wr_last     = 1'b0;

    if (step_i && is_start) begin
      fill_d      = fill_value_i;
      saved_x_d   = rect_x_i;
      saved_w_d   = w_sat;
      rows_left_d = h_sat;
      busy_d      = (w_sat != '0) && (h_sat != '0);
      row_base_d  = rb_start;
      if (busy_d) begin
        seg_d = br_seg;
        if (br_load) begin
          cols_left_d = br_cols;
          write_ptr_d = br_ptr;
        end
      end
    end else if (step_i && busy_q) begin
      emit_o = 1'b1;
      if (cfg_i.pixel_mode == MODE_1BPP) begin
        case (seg_q)
          SEG_ONE: begin
            out_addr = row_base_q + AW'(saved_x_q[11:3]);
            bits8    = lmask & rmask;
            row_done = 1'b1;
          end
          SEG_LEFT: begin
            out_addr = row_base_q + AW'(saved_x_q[11:3]);
            bits8    = lmask;
            if (efx > EFX_W'(sfx)) begin
              seg_d       = SEG_FULL;
              cols_left_d = DIM_W'(efx - EFX_W'(sfx));
              write_ptr_d = row_base_q + AW'(sfx);
            end else if (lb != 3'd0) begin
              seg_d = SEG_RIGHT;
            end else begin
              row_done = 1'b1;
            end
          end
          SEG_FULL: begin
            out_addr    = write_ptr_q;
            bits8       = 8'hff;
            write_ptr_d = write_ptr_q + AW'(1);
            if (cols_left_q <= DIM_W'(1)) begin
              cols_left_d = '0;
              if (lb != 3'd0) seg_d = SEG_RIGHT;
              else row_done = 1'b1;
            end else begin
              cols_left_d = cols_left_q - DIM_W'(1);
            end
          end
          default: begin
            out_addr = row_base_q + AW'(efx);
            bits8    = rmask;
            row_done = 1'b1;
          end
        endcase
        wr_bits = {24'b0, bits8};
        wr_data = {24'b0, color8 & bits8};
      end else begin
        out_addr    = write_ptr_q;
        wr_bits     = pix_bits;
        wr_data     = fill_q & pix_bits;
        write_ptr_d = write_ptr_q + ptr_step;
        if (cols_left_q <= DIM_W'(1)) begin
          cols_left_d = '0;
          row_done    = 1'b1;
        end else begin
          cols_left_d = cols_left_q - DIM_W'(1);
        end
      end

      if (row_done) begin
        if (rows_left_q <= DIM_W'(1)) begin
          rows_left_d = '0;
          busy_d      = 1'b0;
          wr_last     = 1'b1;
        end else begin
          rows_left_d = rows_left_q - DIM_W'(1);
          row_base_d  = rb_next;
          seg_d       = br_seg;
          if (br_load) begin
            cols_left_d = br_cols;
            write_ptr_d = br_ptr;
          end
        end
      end
    end
  end

  assign addr_pad = {32'b0, out_addr};
  assign wr_o     = {addr_pad[31:0], wr_data, wr_bits, wr_last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_base_q  <= '0;
      write_ptr_q <= '0;
      cols_left_q <= '0;
      rows_left_q <= '0;
      busy_q      <= 1'b0;
      seg_q       <= SEG_LEFT;
      fill_q      <= '0;
      saved_x_q   <= '0;
      saved_w_q   <= '0;
    end else begin
      row_base_q  <= row_base_d;
      write_ptr_q <= write_ptr_d;
      cols_left_q <= cols_left_d;
      rows_left_q <= rows_left_d;
      busy_q      <= busy_d;
      seg_q       <= seg_d;
      fill_q      <= fill_d;
      saved_x_q   <= saved_x_d;
      saved_w_q   <= saved_w_d;
    end
  end

endmodule

### sv/rfw_out_reg.sv
// result register between the engine and the write channel
module rfw_out_reg import rfw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  rfw_wr_t wr_i,
  input  logic    ready_i,
  output logic    valid_o,
  output logic    space_o,
  output rfw_wr_t wr_o
);

  logic    valid_q, valid_d;
  rfw_wr_t wr_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      wr_q <= wr_i;
    end
  end

  assign valid_o = valid_q;
  assign wr_o    = wr_q;

endmodule

### sv/rect_fill_write_generator_top.sv
// top level of the rectangle fill write generator
//
// Request channel (in_valid_i/in_ready_o): a start beat latches the
// rectangle and fill value and produces no write; each advance beat while a
// rectangle is in progress produces one masked framebuffer write on the
// write channel (out_valid_o/out_ready_i). An advance beat with no
// rectangle in progress produces nothing.
// Registers fb_base, row_stride and pixel_mode sit on the apb port at
// byte offsets 0, 4 and 8; program them while the block is idle.
// A write appears on the write channel in the cycle after its advance beat is taken.
// The block takes one request beat per cycle while the write channel does not stall,
// set by the combinational walk update and the one-entry result register.
// When the write channel stalls, the result register holds its beat and
// in_ready_o drops until that beat is taken.
// Reset clears the registers, the walk state and the result valid.
module rect_fill_write_generator_top import rfw_pkg::*; #(
  parameter int unsigned MAX_DIM   = DEF_MAX_DIM,
  parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [11:0]        rect_x_i,
  input  logic [11:0]        rect_y_i,
  input  logic [12:0]        rect_w_i,
  input  logic [12:0]        rect_h_i,
  input  logic [31:0]        fill_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        write_addr_o,
  output logic [31:0]        write_data_o,
  output logic [31:0]        write_bits_o,
  output logic               last_write_o
);

  rfw_cfg_t cfg;
  rfw_wr_t  eng_wr;
  rfw_wr_t  out_wr;
  logic     emit;
  logic     space;
  logic     step;

  assign in_ready_o = space;
  assign step       = in_valid_i & space;

  rfw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rfw_engine #(
    .MAX_DIM   (MAX_DIM),
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (step),
    .req_type_i   (req_type_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .fill_value_i (fill_value_i),
    .emit_o       (emit),
    .wr_o         (eng_wr)
  );

  rfw_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .wr_i    (eng_wr),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .space_o (space),
    .wr_o    (out_wr)
  );

  assign write_addr_o = out_wr.write_addr;
  assign write_data_o = out_wr.write_data;
  assign write_bits_o = out_wr.write_bits;
  assign last_write_o = out_wr.last_write;

endmodule

### tb/rect_fill_write_generator_top_tb.sv
// testbench for the rectangle fill write generator: directed and random requests, checked writes
module rect_fill_write_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DIM_LIMIT   = DEF_MAX_DIM;

  typedef struct {
    rfw_req_e    kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] w;
    logic [12:0] h;
    logic [31:0] fill;
  } fill_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               req_type_i;
  logic [11:0]        rect_x_i;
  logic [11:0]        rect_y_i;
  logic [12:0]        rect_w_i;
  logic [12:0]        rect_h_i;
  logic [31:0]        fill_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [31:0]        write_addr_o;
  logic [31:0]        write_data_o;
  logic [31:0]        write_bits_o;
  logic               last_write_o;

  rect_fill_write_generator_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .fill_value_i (fill_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .write_addr_o (write_addr_o),
    .write_data_o (write_data_o),
    .write_bits_o (write_bits_o),
    .last_write_o (last_write_o)
  );

  // register shadow and walk state of the fill engine
  logic [31:0] cfg_base;
  logic [15:0] cfg_stride;
  rfw_mode_e   cfg_mode;
  logic [31:0] walk_row_base;
  logic [31:0] walk_ptr;
  int unsigned walk_cols;
  int unsigned walk_rows;
  bit          walk_busy;
  rfw_seg_e    walk_seg;
  logic [31:0] walk_fill;
  int unsigned walk_x;
  int unsigned walk_w;

  rfw_wr_t     pending_writes[$];
  rfw_wr_t     due_wr;

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned n_items;
  int unsigned n_ignored;
  int unsigned n_writes;
  int unsigned n_lasts;
  int unsigned stall_left;
  bit          idle_en;
  bit          stall_en;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        $error("write beat with nothing pending: write_addr %h", write_addr_o);
        fail_count++;
      end else begin
        due_wr = pending_writes.pop_front();
        n_writes++;
        if (last_write_o) n_lasts++;
        if (write_addr_o !== due_wr.write_addr) begin
          $error("write_addr expected %h actual %h", due_wr.write_addr, write_addr_o);
          fail_count++;
        end
        if (write_data_o !== due_wr.write_data) begin
          $error("write_data expected %h actual %h", due_wr.write_data, write_data_o);
          fail_count++;
        end
        if (write_bits_o !== due_wr.write_bits) begin
          $error("write_bits expected %h actual %h", due_wr.write_bits, write_bits_o);
          fail_count++;
        end
        if (last_write_o !== due_wr.last_write) begin
          $error("last_write expected %b actual %b", due_wr.last_write, last_write_o);
          fail_count++;
        end
      end
    end
  end

  function automatic int unsigned pixel_bytes(rfw_mode_e m);
    case (m)
      MODE_16BPP: return 2;
      MODE_32BPP: return 4;
      default:    return 1;
    endcase
  endfunction

  function automatic void start_row();
    int unsigned first_full;
    int unsigned end_full;
    first_full = (walk_x + 7) >> 3;
    end_full   = (walk_x + walk_w) >> 3;
    if (cfg_mode == MODE_1BPP) begin
      if (first_full > end_full) begin
        walk_seg = SEG_ONE;
      end else if ((walk_x & 7) != 0) begin
        walk_seg = SEG_LEFT;
      end else if (end_full > first_full) begin
        walk_seg  = SEG_FULL;
        walk_cols = end_full - first_full;
        walk_ptr  = walk_row_base + first_full;
      end else begin
        walk_seg = SEG_RIGHT;
      end
    end else begin
      walk_seg  = SEG_FULL;
      walk_cols = walk_w;
      walk_ptr  = walk_row_base + walk_x * pixel_bytes(cfg_mode);
    end
  endfunction

  // advances the walk by one request; returns 0 when the block ignores it
  function automatic bit predict_beat(fill_req_t r);
    int unsigned first_full;
    int unsigned end_full;
    int unsigned tail;
    int unsigned lmask;
    int unsigned rmask;
    int unsigned color;
    int unsigned step;
    rfw_wr_t     wr;
    bit          row_done;
    if (r.kind == REQ_START) begin
      walk_fill     = r.fill;
      walk_x        = 32'(r.x);
      walk_w        = (r.w > DIM_LIMIT) ? DIM_LIMIT : 32'(r.w);
      walk_rows     = (r.h > DIM_LIMIT) ? DIM_LIMIT : 32'(r.h);
      walk_busy     = (walk_w != 0) && (walk_rows != 0);
      walk_row_base = cfg_base + cfg_stride * r.y;
      if (walk_busy) start_row();
      return 1'b1;
    end
    if (!walk_busy) return 1'b0;
    row_done      = 1'b0;
    wr.last_write = 1'b0;
    if (cfg_mode == MODE_1BPP) begin
      first_full = (walk_x + 7) >> 3;
      end_full   = (walk_x + walk_w) >> 3;
      tail       = (walk_x + walk_w) & 7;
      lmask      = 32'hff >> (walk_x & 7);
      rmask      = (32'hff << (8 - tail)) & 32'hff;
      color      = walk_fill[0] ? 32'hff : 32'h0;
      case (walk_seg)
        SEG_ONE: begin
          wr.write_addr = walk_row_base + (walk_x >> 3);
          wr.write_bits = lmask & rmask;
          row_done      = 1'b1;
        end
        SEG_LEFT: begin
          wr.write_addr = walk_row_base + (walk_x >> 3);
          wr.write_bits = lmask;
          if (end_full > first_full) begin
            walk_seg  = SEG_FULL;
            walk_cols = end_full - first_full;
            walk_ptr  = walk_row_base + first_full;
          end else if (tail != 0) begin
            walk_seg = SEG_RIGHT;
          end else begin
            row_done = 1'b1;
          end
        end
        SEG_FULL: begin
          wr.write_addr = walk_ptr;
          wr.write_bits = 32'hff;
          walk_ptr      = walk_ptr + 1;
          if (walk_cols <= 1) begin
            walk_cols = 0;
            if (tail != 0) walk_seg = SEG_RIGHT;
            else row_done = 1'b1;
          end else begin
            walk_cols--;
          end
        end
        default: begin
          wr.write_addr = walk_row_base + end_full;
          wr.write_bits = rmask;
          row_done      = 1'b1;
        end
      endcase
      wr.write_data = color & wr.write_bits;
    end else begin
      step          = pixel_bytes(cfg_mode);
      wr.write_addr = walk_ptr;
      wr.write_bits = (step == 4) ? 32'hffff_ffff : ((step == 2) ? 32'hffff : 32'hff);
      wr.write_data = walk_fill & wr.write_bits;
      walk_ptr      = walk_ptr + step;
      if (walk_cols <= 1) begin
        walk_cols = 0;
        row_done  = 1'b1;
      end else begin
        walk_cols--;
      end
    end
    if (row_done) begin
      if (walk_rows <= 1) begin
        walk_rows     = 0;
        walk_busy     = 1'b0;
        wr.last_write = 1'b1;
      end else begin
        walk_rows--;
        walk_row_base = walk_row_base + cfg_stride;
        start_row();
      end
    end
    pending_writes.push_back(wr);
    return 1'b1;
  endfunction

  function automatic fill_req_t rect_req(logic [11:0] x, logic [11:0] y, logic [12:0] w,
                                         logic [12:0] h, logic [31:0] fill);
    fill_req_t r;
    r.kind = REQ_START;
    r.x    = x;
    r.y    = y;
    r.w    = w;
    r.h    = h;
    r.fill = fill;
    return r;
  endfunction

  function automatic fill_req_t adv_req();
    fill_req_t r;
    r      = rect_req(12'($urandom), 12'($urandom), 13'($urandom), 13'($urandom), $urandom);
    r.kind = REQ_ADVANCE;
    return r;
  endfunction

  function automatic fill_req_t rand_rect(bit wild);
    fill_req_t r;
    r = rect_req(12'($urandom), 12'($urandom), 13'd0, 13'd0, $urandom);
    if (wild) begin
      r.w = 13'($urandom_range(0, 8191));
      r.h = 13'($urandom_range(0, 8191));
    end else if (cfg_mode == MODE_1BPP) begin
      r.w = 13'($urandom_range(1, 40));
      r.h = 13'($urandom_range(1, 3));
    end else begin
      r.w = 13'($urandom_range(1, 6));
      r.h = 13'($urandom_range(1, 3));
    end
    return r;
  endfunction

  task automatic send_req(fill_req_t r);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    req_type_i   <= r.kind;
    rect_x_i     <= r.x;
    rect_y_i     <= r.y;
    rect_w_i     <= r.w;
    rect_h_i     <= r.h;
    fill_value_i <= r.fill;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_beat(r)) n_items++;
    else n_ignored++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FB_BASE:    cfg_base = val;
      REG_ROW_STRIDE: cfg_stride = val[15:0];
      REG_PIXEL_MODE: cfg_mode = rfw_mode_e'(val[1:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] base, logic [15:0] stride, rfw_mode_e mode);
    apb_write(REG_FB_BASE, base);
    apb_write(REG_ROW_STRIDE, {16'h0, stride});
    apb_write(REG_PIXEL_MODE, {30'h0, mode});
  endtask

  task automatic finish_rect();
    while (walk_busy) send_req(adv_req());
  endtask

  task automatic test_pixel_modes();
    wait_drained();
    set_config(32'hffff_fff0, 16'hffff, MODE_8BPP);
    send_req(rect_req(12'hfff, 12'hfff, 13'd2, 13'd1, 32'hffff_ffff));
    finish_rect();
    send_req(adv_req());
    wait_drained();
    set_config(32'h1000_0000, 16'h0100, MODE_16BPP);
    send_req(rect_req(12'h000, 12'h000, 13'd1, 13'd2, 32'h1234_8765));
    finish_rect();
    wait_drained();
    set_config(32'h0000_0000, 16'h0000, MODE_32BPP);
    send_req(rect_req(12'h001, 12'h007, 13'd1, 13'd1, 32'ha5a5_5a5a));
    finish_rect();
  endtask

  task automatic test_one_bpp_segments();
    wait_drained();
    set_config(32'h2000_0000, 16'd640, MODE_1BPP);
    // row inside one byte
    send_req(rect_req(12'd1, 12'd2, 13'd3, 13'd1, 32'h1));
    finish_rect();
    // aligned left edge
    send_req(rect_req(12'd8, 12'd3, 13'd12, 13'd1, 32'h1));
    finish_rect();
    send_req(rect_req(12'd3, 12'd4, 13'd14, 13'd1, 32'hffff_fffe));
    finish_rect();
    // left byte only, ending on a byte boundary
    send_req(rect_req(12'd5, 12'd5, 13'd3, 13'd2, 32'h1));
    finish_rect();
  endtask

  task automatic test_degenerate_rects();
    wait_drained();
    set_config(32'h0000_0040, 16'd4, MODE_8BPP);
    send_req(rect_req(12'd0, 12'd0, 13'd0, 13'd5, 32'h0));
    send_req(adv_req());
    send_req(rect_req(12'd0, 12'd0, 13'd5, 13'd0, 32'h0));
    send_req(adv_req());
    // oversized, then aborted by an empty start
    send_req(rect_req(12'hfff, 12'hfff, 13'h1fff, 13'h1fff, 32'h8000_0001));
    send_req(adv_req());
    send_req(adv_req());
    send_req(rect_req(12'd0, 12'd0, 13'd0, 13'd0, 32'h0));
  endtask

  task automatic test_random_fills();
    int unsigned seg_start;
    int unsigned pick;
    bit          paused;
    fill_req_t   r;
    for (int s = 0; s < 8; s++) begin
      wait_drained();
      case (s)
        0:       set_config(32'h0000_0000, 16'h0000, MODE_8BPP);
        1:       set_config(32'hffff_ffff, 16'hffff, MODE_16BPP);
        default: set_config($urandom, 16'($urandom), rfw_mode_e'(s[1:0]));
      endcase
      idle_en   = (s != 4) && (s != 7);
      stall_en  = idle_en;
      seg_start = n_items;
      paused    = 1'b0;
      while (n_items - seg_start < 50) begin
        pick = $urandom_range(0, 9);
        send_req(rand_rect(pick == 0));
        if (pick <= 1) begin
          repeat ($urandom_range(0, 5)) send_req(adv_req());
        end else begin
          while (walk_busy) begin
            send_req(adv_req());
            if (!paused) begin
              paused = 1'b1;
              wait_drained();
            end
          end
          if ($urandom_range(0, 3) == 0) send_req(adv_req());
        end
      end
      // leave the block idle for the next register writes
      r   = rand_rect(1'b0);
      r.w = 13'd0;
      send_req(r);
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_START;
    rect_x_i     = '0;
    rect_y_i     = '0;
    rect_w_i     = '0;
    rect_h_i     = '0;
    fill_value_i = '0;
    out_ready_i  = 1'b0;
    idle_en      = 1'b1;
    stall_en     = 1'b1;
    cfg_base     = '0;
    cfg_stride   = '0;
    cfg_mode     = MODE_8BPP;
    walk_busy    = 1'b0;
    walk_seg     = SEG_LEFT;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pixel_modes();
    test_one_bpp_segments();
    test_degenerate_rects();
    test_random_fills();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("tb: %0d requests accepted (%0d advances while idle), %0d writes checked",
             n_items + n_ignored, n_ignored, n_writes);
    $display("tb: %0d rectangles completed over 8, 16, 32 and 1 bpp layouts", n_lasts);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
